[hdl/shamh_pkg.sv]
// shared types and helpers for the sha-256 message hasher
`default_nettype none

package shamh_pkg;

  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned WIN_WORDS = 16;

  typedef logic [31:0] word_t;

  // control from the sequencer to the schedule window and the round unit
  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic       load;
    logic       round;
    logic [5:0] rnd;
  } ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

[hdl/shamh_intf.sv]
// valid/ready channel interfaces for message bytes and digest words
`default_nettype none

interface shamh_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface shamh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        length_overflow;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  output length_overflow, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                input length_overflow, output ready);
endinterface

`default_nettype wire

[hdl/shamh_sched.sv]
// block buffer that doubles as the 16-word message schedule window
`default_nettype none

module shamh_sched (
  input  logic             clk,
  input  shamh_pkg::ctl_t  ctl,
  input  logic [7:0]       byte_in,
  output shamh_pkg::word_t w_out
);
  import shamh_pkg::*;

  word_t win_r [WIN_WORDS];
  word_t sched_word;

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // w[t+16] from the window holding w[t] .. w[t+15]
  assign sched_word = win_r[0] + small_sigma0(win_r[1]) + win_r[9] + small_sigma1(win_r[14]);

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[WIN_WORDS-1] <= {win_r[WIN_WORDS-1][23:0], byte_in};
    end else if (ctl.shift_word) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_WORDS-1] <= sched_word;
    end
  end

  assign w_out = win_r[0];

endmodule

`default_nettype wire

[hdl/shamh_round.sv]
// working variables a..h and the shared one-round compression unit
`default_nettype none

module shamh_round (
  input  logic                                       clk,
  input  shamh_pkg::ctl_t                            ctl,
  input  shamh_pkg::word_t [shamh_pkg::NUM_WORDS-1:0] chain_in,
  input  shamh_pkg::word_t                           w_in,
  output shamh_pkg::word_t [shamh_pkg::NUM_WORDS-1:0] v_out
);
  import shamh_pkg::*;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  word_t [NUM_WORDS-1:0] v_r;
  word_t t1;
  word_t t2;

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  always_comb begin
    t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + ROUND_K[ctl.rnd] + w_in;
    t2 = big_sigma0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v_r <= chain_in;
    end else if (ctl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign v_out = v_r;

endmodule

`default_nettype wire

[hdl/sha256_message_hasher.sv]
// sha-256 message hasher top level: sequencer, chaining words and digest output
//
// usage
//   in_chan carries one transaction per message byte (mode 0, data_byte) or a
//   finish transaction (mode 1). out_chan carries the eight digest words of a
//   message, word_index 0 (H0) first, last_word set on word 7, length_overflow
//   set on all eight when the message ran past 2^61-1 bytes.
// timing
//   a byte is taken per in_chan transfer; every 64th byte starts a block
//   compression, the rounds followed by the chaining add, during which in_chan
//   is not ready. the sustained byte rate is set by the single shared round
//   unit and the byte-wide buffer shift.
//   finish shifts the padding in one byte per cycle, runs a compression (twice
//   when more than 55 bytes were buffered), then hands out the digest at one
//   word per cycle while out_ready stays high.
// reset and stall
//   synchronous reset loads the initial hash values and clears the byte count,
//   fill count and overflow flag. the digest goes through an output register;
//   a stalled receiver holds it, and once the last word sits there the block
//   accepts the next message.
`default_nettype none

module sha256_message_hasher (
  input  logic               clk,
  input  logic               rst_n,
  shamh_in_if.sink           in_chan,
  shamh_out_if.source        out_chan
);
  import shamh_pkg::*;

  localparam word_t [NUM_WORDS-1:0] INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };
  localparam logic [60:0] LEN_MAX  = '1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam logic [5:0]  LAST_POS = 6'd63;
  localparam logic [2:0]  LAST_IDX = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  word_t [NUM_WORDS-1:0] chain_r, chain_nxt;
  logic [5:0]            fill_r, fill_nxt;
  logic [60:0]           total_r, total_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  fin_r, fin_nxt;     // finish in progress
  logic                  first_r, first_nxt; // next pad byte is the 0x80 marker
  logic                  wrap_r, wrap_nxt;   // marker landed past 55, extra block
  logic                  done_r, done_nxt;   // length bytes are in, last block
  logic [5:0]            rnd_r, rnd_nxt;
  logic [2:0]            emit_idx_r, emit_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  word_t                 out_word_r, out_word_nxt;
  logic [2:0]            out_idx_r, out_idx_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  ctl_t                  ctl;
  logic [7:0]            byte_in;
  logic [63:0]           bit_len;
  word_t                 sched_w;
  word_t [NUM_WORDS-1:0] v_work;

  shamh_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .byte_in (byte_in),
    .w_out   (sched_w)
  );

  shamh_round u_round (
    .clk      (clk),
    .ctl      (ctl),
    .chain_in (chain_r),
    .w_in     (sched_w),
    .v_out    (v_work)
  );

  assign bit_len = {total_r, 3'b000};

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    fin_nxt       = fin_r;
    first_nxt     = first_r;
    wrap_nxt      = wrap_r;
    done_nxt      = done_r;
    rnd_nxt       = rnd_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ctl           = '0;
    ctl.rnd       = rnd_r;
    byte_in       = in_chan.data_byte;

    // output register drains when the receiver takes the word
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (!in_chan.mode) begin
            ctl.shift_byte = 1'b1;
            fill_nxt       = fill_r + 6'd1;
            if (total_r == LEN_MAX) begin
              ovf_nxt = 1'b1;
            end else begin
              total_nxt = total_r + 61'd1;
            end
            // buffer full: start compression
            if (fill_r == LAST_POS) begin
              ctl.load  = 1'b1;
              rnd_nxt   = '0;
              state_nxt = ST_COMP;
            end
          end else begin
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        ctl.shift_byte = 1'b1;
        fill_nxt       = fill_r + 6'd1;
        first_nxt      = 1'b0;
        if (first_r) begin
          byte_in = PAD_BYTE;
          if (fill_r >= LEN_POS) begin
            wrap_nxt = 1'b1;
          end
        end else if (fill_r >= LEN_POS && !wrap_r) begin
          // big-endian bit length in the last eight positions
          byte_in = bit_len[{LAST_IDX - fill_r[2:0], 3'b000} +: 8];
        end else begin
          byte_in = 8'h00;
        end
        if (!first_r && !wrap_r && fill_r == LAST_POS) begin
          done_nxt = 1'b1;
        end
        if (fill_r == LAST_POS) begin
          wrap_nxt  = 1'b0;
          ctl.load  = 1'b1;
          rnd_nxt   = '0;
          state_nxt = ST_COMP;
        end
      end

      ST_COMP: begin
        ctl.round      = 1'b1;
        ctl.shift_word = 1'b1;
        rnd_nxt        = rnd_r + 6'd1;
        if (rnd_r == LAST_POS) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + v_work[i];
        end
        emit_idx_nxt = '0;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (done_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_r[emit_idx_r];
          out_idx_nxt   = emit_idx_r;
          out_last_nxt  = (emit_idx_r == LAST_IDX);
          out_ovf_nxt   = ovf_r;
          emit_idx_nxt  = emit_idx_r + 3'd1;
          // last word loaded into the output register: back to the initial values
          if (emit_idx_r == LAST_IDX) begin
            chain_nxt = INIT_H;
            total_nxt = '0;
            ovf_nxt   = 1'b0;
            fin_nxt   = 1'b0;
            done_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= INIT_H;
      fill_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      fin_r       <= 1'b0;
      first_r     <= 1'b0;
      wrap_r      <= 1'b0;
      done_r      <= 1'b0;
      rnd_r       <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      fin_r       <= fin_nxt;
      first_r     <= first_nxt;
      wrap_r      <= wrap_nxt;
      done_r      <= done_nxt;
      rnd_r       <= rnd_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // digest payload, no reset needed
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_chan.ready            = (state_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.digest_word     = out_word_r;
  assign out_chan.word_index      = out_idx_r;
  assign out_chan.last_word       = out_last_r;
  assign out_chan.length_overflow = out_ovf_r;

  // a compression always starts on an empty buffer
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && $past(state_r) != ST_COMP) |-> fill_r == '0)
    else $error("compression started with bytes left in the buffer");

  // last word flag only on the final digest word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_idx_r == LAST_IDX)
    else $error("last word flag on the wrong digest word");

  // overflow only once the byte count has saturated
  assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> total_r == LEN_MAX)
    else $error("overflow flag set below the length limit");

  // the length block cannot be closed while an extra block is still pending
  assert property (@(posedge clk) disable iff (!rst_n)
    wrap_r |-> !done_r)
    else $error("padding marked done with an extra block pending");

  // digest is only handed out after the final block is folded in
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (fin_r && done_r && fill_r == '0))
    else $error("digest output before padding finished");

endmodule

`default_nettype wire
